@@ hdl/inner_lagrange_point_newton_solver_defines.svh @@
// Assertion macros for the inner Lagrange point solver.
`ifndef INNER_LAGRANGE_POINT_NEWTON_SOLVER_DEFINES_SVH
`define INNER_LAGRANGE_POINT_NEWTON_SOLVER_DEFINES_SVH

`ifndef SYNTHESIS
`define ILP_ASSERT(name, prop) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("ilpns assertion failed");
`define ILP_ASSERT_NEVER(name, cond) \
	name: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error("ilpns forbidden condition");
`else
`define ILP_ASSERT(name, prop)
`define ILP_ASSERT_NEVER(name, cond)
`endif

`endif

@@ hdl/ilpns_pkg.sv @@
package ilpns_pkg;

	localparam logic signed [63:0] SMAX  = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0]        ONE48 = 64'h0001_0000_0000_0000;
	localparam logic [63:0]        QONE  = 64'h0000_0000_0001_0000;

	localparam logic [0:0] CFG_MAX_ITER = 1'b0;
	localparam logic [0:0] CFG_STEP_TOL = 1'b1;

	typedef struct packed {
		logic               kind;
		logic [31:0]        mass_ratio;
		logic signed [31:0] spin_factor;
	} in_t;

	typedef struct packed {
		logic [30:0] position;
		logic [1:0]  status;
		logic [9:0]  iterations_used;
	} out_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_QZERO  = 2'd1,
		ST_NOCONV = 2'd2
	} stat_t;

	typedef enum logic {
		MS_SSQ,
		MS_HORNER
	} msel_t;

	typedef enum logic [1:0] {
		DS_MU,
		DS_X0,
		DS_STEP
	} dsel_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_QCHK,
		S_SSQ,
		S_MU,
		S_X0,
		S_TEST,
		S_HMUL,
		S_HWAIT,
		S_PEND,
		S_STEP,
		S_FIN
	} state_t;

	typedef struct packed {
		logic       load;
		logic       mul_go;
		msel_t      mul_sel;
		logic       div_go;
		dsel_t      div_sel;
		logic       ssq_we;
		logic       mu_we;
		logic       x0_we;
		logic       acc_init;
		logic       acc_mac;
		logic [2:0] coef_idx;
		logic       deriv;
		logic       f_we;
		logic       x_upd;
		logic       fin;
		stat_t      fin_stat;
	} cmd_t;

	typedef struct packed {
		logic q_zero;
		logic mul_done;
		logic div_done;
		logic cont;
		logic at_limit;
		logic df_zero;
	} sts_t;

	function automatic logic signed [63:0] sat_add(
		input logic signed [63:0] a,
		input logic signed [63:0] b
	);
		logic signed [64:0] s;
		logic signed [63:0] r;
		s = {a[63], a} + {b[63], b};
		if (s > $signed({1'b0, SMAX}))
			r = SMAX;
		else if (s < -$signed({1'b0, SMAX}))
			r = -SMAX;
		else
			r = s[63:0];
		return r;
	endfunction

	function automatic logic signed [63:0] fmul_fin(
		input logic [127:0] p,
		input logic         neg
	);
		logic [63:0] m;
		m = (|p[127:111]) ? SMAX : {1'b0, p[110:48]};
		return neg ? -$signed(m) : $signed(m);
	endfunction

endpackage

@@ hdl/ilpns_datapath.sv @@
module ilpns_datapath import ilpns_pkg::*; #(
	parameter int DATA_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [0:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  in_t         in_data,
	input  cmd_t        cmd,
	output sts_t        sts,
	output out_t        out_data
);

	localparam logic [63:0] WMASK = (64'd1 << DATA_WIDTH) - 64'd1;
	localparam logic [63:0] WTOP  = 64'd1 << DATA_WIDTH;
	localparam logic [63:0] HALF  = 64'd1 << 17;

	logic [9:0]  maxit_q;
	logic [15:0] tol_q;

	logic               kind_q;
	logic [63:0]        q_q, smag_q;
	logic signed [63:0] ssq_q, mu_q, x_q, acc_q, f_q;
	logic [63:0]        dmag_q;
	logic [9:0]         n_q;

	logic [63:0]  ma_q, mb_q;
	logic         mneg_q, mbusy_q, mdone_q;
	logic [1:0]   mcnt_q;
	logic [127:0] prod_q;

	logic [127:0] num_q;
	logic [63:0]  den_q, rem_q, quo_q;
	logic         ovf_q, dbusy_q, ddone_q;
	logic [6:0]   dcnt_q;

	logic [63:0]        q_in, sraw, smag_in;
	logic [63:0]        acc_mag, x_mag, f_mag;
	logic [31:0]        pa, pb;
	logic [63:0]        pp;
	logic [127:0]       pp_sh;
	logic [64:0]        r_try;
	logic               r_ge;
	logic signed [63:0] fm, coef, div_res, step, xn;
	logic signed [63:0] a1, a2, a3, a4, a5, a6;
	logic [63:0]        rnd;
	logic [45:0]        rq;
	logic [30:0]        pos;

	assign q_in    = {32'd0, in_data.mass_ratio} & WMASK;
	assign sraw    = {32'd0, in_data.spin_factor} & WMASK;
	assign smag_in = sraw[DATA_WIDTH-1] ? (WTOP - sraw) : sraw;
	assign acc_mag = acc_q[63] ? 64'(-acc_q) : acc_q;
	assign x_mag   = x_q[63] ? 64'(-x_q) : x_q;
	assign f_mag   = f_q[63] ? 64'(-f_q) : f_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			maxit_q <= 10'd1000;
			tol_q   <= 16'd1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_MAX_ITER: maxit_q <= cfg_data[9:0];
				CFG_STEP_TOL: tol_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// coefficients of the quintic and its derivative
	always_comb begin
		a1 = mu_q - ONE48;
		a2 = (ONE48 <<< 1) - (mu_q <<< 1);
		a6 = ssq_q;
		if (!kind_q) begin
			a3 = mu_q - ONE48;
			a4 = ssq_q + (mu_q <<< 1);
			a5 = -(ssq_q <<< 1) - mu_q;
		end else begin
			a3 = mu_q - ssq_q;
			a4 = 3 * ssq_q + (mu_q <<< 1) - (ONE48 <<< 1);
			a5 = ONE48 - mu_q - 3 * ssq_q;
		end
		case ({cmd.deriv, cmd.coef_idx})
			4'b0001: coef = a1;
			4'b0010: coef = a2;
			4'b0011: coef = a3;
			4'b0100: coef = a4;
			4'b0101: coef = a5;
			4'b0110: coef = a6;
			4'b1001: coef = a2;
			4'b1010: coef = a3 <<< 1;
			4'b1011: coef = 3 * a4;
			4'b1100: coef = a5 <<< 2;
			4'b1101: coef = 5 * a6;
			default: coef = '0;
		endcase
	end

	// multiplier: one 32x32 partial product per cycle
	assign pa = mcnt_q[0] ? ma_q[63:32] : ma_q[31:0];
	assign pb = mcnt_q[1] ? mb_q[63:32] : mb_q[31:0];
	assign pp = pa * pb;

	always_comb begin
		case (mcnt_q)
			2'd0:    pp_sh = {64'd0, pp};
			2'd3:    pp_sh = {pp, 64'd0};
			default: pp_sh = {32'd0, pp, 32'd0};
		endcase
	end

	assign fm = fmul_fin(prod_q, mneg_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mbusy_q <= 1'b0;
			mdone_q <= 1'b0;
			mcnt_q  <= '0;
		end else begin
			mdone_q <= mbusy_q && (mcnt_q == 2'd3);
			if (cmd.mul_go) begin
				mbusy_q <= 1'b1;
				mcnt_q  <= '0;
			end else if (mbusy_q) begin
				mcnt_q <= mcnt_q + 2'd1;
				if (mcnt_q == 2'd3)
					mbusy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mul_go) begin
			prod_q <= '0;
			if (cmd.mul_sel == MS_SSQ) begin
				ma_q   <= smag_q;
				mb_q   <= smag_q;
				mneg_q <= 1'b0;
			end else begin
				ma_q   <= acc_mag;
				mb_q   <= x_mag;
				mneg_q <= acc_q[63] ^ x_q[63];
			end
		end else if (mbusy_q) begin
			prod_q <= prod_q + pp_sh;
		end
	end

	// divider: floor(a * 2^48 / b), one quotient bit per cycle
	assign r_try   = {rem_q, num_q[127]};
	assign r_ge    = r_try >= {1'b0, den_q};
	assign div_res = (ovf_q || quo_q[63]) ? SMAX : $signed(quo_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dbusy_q <= 1'b0;
			ddone_q <= 1'b0;
			dcnt_q  <= '0;
		end else begin
			ddone_q <= dbusy_q && (dcnt_q == 7'd127);
			if (cmd.div_go) begin
				dbusy_q <= 1'b1;
				dcnt_q  <= '0;
			end else if (dbusy_q) begin
				dcnt_q <= dcnt_q + 7'd1;
				if (dcnt_q == 7'd127)
					dbusy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_go) begin
			rem_q <= '0;
			quo_q <= '0;
			ovf_q <= 1'b0;
			unique case (cmd.div_sel)
				DS_MU: begin
					num_q <= {16'd0, q_q, 48'd0};
					den_q <= QONE + q_q;
				end
				DS_X0: begin
					num_q <= {16'd0, QONE, 48'd0};
					den_q <= QONE + q_q;
				end
				default: begin
					num_q <= {16'd0, f_mag, 48'd0};
					den_q <= acc_mag;
				end
			endcase
		end else if (dbusy_q) begin
			num_q <= {num_q[126:0], 1'b0};
			rem_q <= r_ge ? 64'(r_try - {1'b0, den_q}) : r_try[63:0];
			quo_q <= {quo_q[62:0], r_ge};
			ovf_q <= ovf_q | quo_q[63];
		end
	end

	assign step = (f_q[63] ^ acc_q[63]) ? -div_res : div_res;
	assign xn   = sat_add(x_q, -step);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q <= in_data.kind;
			q_q    <= q_in;
			smag_q <= smag_in;
			n_q    <= '0;
		end
		if (cmd.ssq_we)
			ssq_q <= $signed({8'd0, prod_q[63:8]});
		if (cmd.mu_we)
			mu_q <= div_res;
		if (cmd.x0_we) begin
			x_q    <= div_res;
			dmag_q <= div_res;
		end
		if (cmd.f_we)
			f_q <= acc_q;
		if (cmd.acc_init)
			acc_q <= coef;
		else if (cmd.acc_mac)
			acc_q <= sat_add(fm, coef);
		if (cmd.x_upd) begin
			x_q    <= xn;
			dmag_q <= (xn >= x_q) ? 64'(xn - x_q) : 64'(x_q - xn);
			n_q    <= n_q + 10'd1;
		end
	end

	// round half up to Q1.30 and clamp to one
	assign rnd = x_q + HALF;
	assign rq  = rnd[63:18];
	assign pos = (rq > 46'(64'd1 << 30)) ? 31'(64'd1 << 30) : rq[30:0];

	always_ff @(posedge clk) begin
		if (cmd.fin) begin
			out_data.status          <= cmd.fin_stat;
			out_data.iterations_used <= n_q;
			out_data.position        <= (cmd.fin_stat == ST_OK && x_q > 0) ? pos : '0;
		end
	end

	assign sts.q_zero   = (q_q == '0);
	assign sts.mul_done = mdone_q;
	assign sts.div_done = ddone_q;
	assign sts.cont     = (n_q < maxit_q) && (dmag_q > {30'd0, tol_q, 18'd0});
	assign sts.at_limit = (n_q == maxit_q);
	assign sts.df_zero  = (acc_q == '0);

endmodule

@@ hdl/ilpns_ctrl.sv @@
`include "inner_lagrange_point_newton_solver_defines.svh"

module ilpns_ctrl import ilpns_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t     state_q, state_n;
	logic [2:0] k_q, k_n;
	logic       deriv_q, deriv_n;
	stat_t      stat_q, stat_n;
	logic       out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			k_q         <= '0;
			deriv_q     <= 1'b0;
			stat_q      <= ST_OK;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			k_q     <= k_n;
			deriv_q <= deriv_n;
			stat_q  <= stat_n;
			if (cmd.fin)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		state_n      = state_q;
		k_n          = k_q;
		deriv_n      = deriv_q;
		stat_n       = stat_q;
		in_ready     = 1'b0;
		cmd          = '0;
		cmd.mul_sel  = MS_HORNER;
		cmd.div_sel  = DS_STEP;
		cmd.fin_stat = stat_q;
		cmd.coef_idx = k_q;
		cmd.deriv    = deriv_q;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_n  = S_QCHK;
				end
			end
			S_QCHK: begin
				if (sts.q_zero) begin
					stat_n  = ST_QZERO;
					state_n = S_FIN;
				end else begin
					cmd.mul_go  = 1'b1;
					cmd.mul_sel = MS_SSQ;
					state_n     = S_SSQ;
				end
			end
			S_SSQ: begin
				if (sts.mul_done) begin
					cmd.ssq_we  = 1'b1;
					cmd.div_go  = 1'b1;
					cmd.div_sel = DS_MU;
					state_n     = S_MU;
				end
			end
			S_MU: begin
				if (sts.div_done) begin
					cmd.mu_we   = 1'b1;
					cmd.div_go  = 1'b1;
					cmd.div_sel = DS_X0;
					state_n     = S_X0;
				end
			end
			S_X0: begin
				if (sts.div_done) begin
					cmd.x0_we = 1'b1;
					state_n   = S_TEST;
				end
			end
			S_TEST: begin
				if (sts.cont) begin
					cmd.acc_init = 1'b1;
					cmd.coef_idx = 3'd6;
					cmd.deriv    = 1'b0;
					k_n          = 3'd5;
					deriv_n      = 1'b0;
					state_n      = S_HMUL;
				end else begin
					stat_n  = sts.at_limit ? ST_NOCONV : ST_OK;
					state_n = S_FIN;
				end
			end
			S_HMUL: begin
				cmd.mul_go = 1'b1;
				state_n    = S_HWAIT;
			end
			S_HWAIT: begin
				if (sts.mul_done) begin
					cmd.acc_mac = 1'b1;
					if (k_q == 3'd1) begin
						state_n = S_PEND;
					end else begin
						k_n     = k_q - 3'd1;
						state_n = S_HMUL;
					end
				end
			end
			S_PEND: begin
				if (!deriv_q) begin
					cmd.f_we     = 1'b1;
					cmd.acc_init = 1'b1;
					cmd.coef_idx = 3'd5;
					cmd.deriv    = 1'b1;
					k_n          = 3'd4;
					deriv_n      = 1'b1;
					state_n      = S_HMUL;
				end else if (sts.df_zero) begin
					stat_n  = ST_NOCONV;
					state_n = S_FIN;
				end else begin
					cmd.div_go = 1'b1;
					state_n    = S_STEP;
				end
			end
			S_STEP: begin
				if (sts.div_done) begin
					cmd.x_upd = 1'b1;
					state_n   = S_TEST;
				end
			end
			S_FIN: begin
				if (!out_valid_q || out_ready) begin
					cmd.fin = 1'b1;
					state_n = S_IDLE;
				end
			end
			default: state_n = S_IDLE;
		endcase
	end

	assign out_valid = out_valid_q;

	`ILP_ASSERT_NEVER(a_one_unit, cmd.mul_go && cmd.div_go)
	`ILP_ASSERT(a_upd_after_div, cmd.x_upd |-> sts.div_done)
	`ILP_ASSERT(a_mul_latency, cmd.mul_go |=> !sts.mul_done)

endmodule

@@ hdl/inner_lagrange_point_newton_solver.sv @@
// channel | direction | handshake            | beat
// in      | input     | in_valid / in_ready   | in_t: kind, mass_ratio, spin_factor
// out     | output    | out_valid / out_ready | out_t: position, status, iterations_used
// cfg     | input     | cfg_we                | cfg_index, cfg_data
//
// One request at a time; a zero mass ratio goes from the check straight to the finish.
// Otherwise setup is one multiply and two divides, and each Newton step is made of
// nine multiplies and one divide on the shared divider.
// A finished beat waits in the output register while a new request is taken.
// Reset restores max_iterations 1000 and step_tolerance 1 and clears control.
module inner_lagrange_point_newton_solver import ilpns_pkg::*; #(
	parameter int DATA_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [0:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  in_t         in_data,
	output logic        out_valid,
	input  logic        out_ready,
	output out_t        out_data
);

	cmd_t cmd;
	sts_t sts;

	ilpns_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	ilpns_datapath #(
		.DATA_WIDTH (DATA_WIDTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_data   (in_data),
		.cmd       (cmd),
		.sts       (sts),
		.out_data  (out_data)
	);

endmodule

@@ verif/inner_lagrange_point_newton_solver_tb.sv @@
`timescale 1ns / 1ps

module inner_lagrange_point_newton_solver_tb;
	import ilpns_pkg::*;

	localparam int          STALL_LIMIT = 600000;
	localparam longint      WMAX        = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam longint      W_ONE       = 64'sh0001_0000_0000_0000;

	class lagrange_scoreboard;
		out_t        solutions[$];
		logic [9:0]  iter_limit;
		logic [15:0] tol_lsbs;
		int          mismatches;

		function new();
			iter_limit = 10'd1000;
			tol_lsbs   = 16'd1;
			mismatches = 0;
		endfunction

		function longint add_sat(longint a, longint b);
			logic signed [64:0] s;
			s = {a[63], a} + {b[63], b};
			if (s > 65'sd9223372036854775807)
				return WMAX;
			if (s < -65'sd9223372036854775807)
				return -WMAX;
			return s[63:0];
		endfunction

		function logic [63:0] mag(longint v);
			return v < 0 ? -v : v;
		endfunction

		function longint mul_q48(longint a, longint b);
			logic [127:0] p;
			logic [63:0]  m;
			p = {64'd0, mag(a)} * {64'd0, mag(b)};
			if (|p[127:111])
				m = WMAX;
			else
				m = {1'b0, p[110:48]};
			return ((a < 0) != (b < 0)) ? -longint'(m) : longint'(m);
		endfunction

		function logic [63:0] div_q48(logic [63:0] a, logic [63:0] b);
			logic [127:0] n;
			logic [127:0] qq;
			n  = {16'd0, a, 48'd0};
			qq = n / {64'd0, b};
			if (qq > {64'd0, WMAX})
				return WMAX;
			return qq[63:0];
		endfunction

		function out_t predict(in_t d);
			out_t        r;
			logic [63:0] smag, tol, dmag;
			longint      mu, ssq, a1, a2, a3, a4, a5, a6, d1, d2, d3, d4, d5, x;
			longint      f, df, stp, xn;
			logic [63:0] rp;
			int          n;
			bit          dead;
			r    = '0;
			n    = 0;
			dead = 0;
			if (d.mass_ratio == 0) begin
				r.status = ST_QZERO;
				return r;
			end
			smag = d.spin_factor[31] ? (64'h1_0000_0000 - {32'd0, d.spin_factor})
				: {32'd0, d.spin_factor};
			ssq  = (smag * smag) >> 8;
			mu   = div_q48({32'd0, d.mass_ratio}, 64'd65536 + d.mass_ratio);
			x    = div_q48(64'd65536, 64'd65536 + d.mass_ratio);
			a1 = mu - W_ONE;
			a2 = 2 * W_ONE - 2 * mu;
			a6 = ssq;
			if (!d.kind) begin
				a3 = mu - W_ONE;
				a4 = ssq + 2 * mu;
				a5 = -2 * ssq - mu;
			end else begin
				a3 = mu - ssq;
				a4 = 3 * ssq + 2 * mu - 2 * W_ONE;
				a5 = W_ONE - mu - 3 * ssq;
			end
			d1 = a2; d2 = 2 * a3; d3 = 3 * a4; d4 = 4 * a5; d5 = 5 * a6;
			tol  = {48'd0, tol_lsbs} << 18;
			dmag = x;
			while (n < iter_limit && dmag > tol) begin
				f  = add_sat(mul_q48(a6, x), a5);
				f  = add_sat(mul_q48(f, x), a4);
				f  = add_sat(mul_q48(f, x), a3);
				f  = add_sat(mul_q48(f, x), a2);
				f  = add_sat(mul_q48(f, x), a1);
				df = add_sat(mul_q48(d5, x), d4);
				df = add_sat(mul_q48(df, x), d3);
				df = add_sat(mul_q48(df, x), d2);
				df = add_sat(mul_q48(df, x), d1);
				if (df == 0) begin
					dead = 1;
					break;
				end
				stp = div_q48(mag(f), mag(df));
				if ((f < 0) != (df < 0))
					stp = -stp;
				xn   = add_sat(x, -stp);
				dmag = xn >= x ? xn - x : x - xn;
				x    = xn;
				n++;
			end
			r.iterations_used = n[9:0];
			if (dead || n == iter_limit) begin
				r.status = ST_NOCONV;
				return r;
			end
			r.status = ST_OK;
			if (x > 0) begin
				rp = (x + (64'd1 << 17)) >> 18;
				if (rp > (64'd1 << 30))
					rp = 64'd1 << 30;
				r.position = rp[30:0];
			end
			return r;
		endfunction

		function void note(in_t d);
			solutions.push_back(predict(d));
		endfunction

		function void check(out_t got);
			out_t want;
			if (solutions.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected beat pos=%0d st=%0d it=%0d",
						got.position, got.status, got.iterations_used);
				return;
			end
			want = solutions.pop_front();
			if (got !== want) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch exp pos=%0d st=%0d it=%0d act pos=%0d st=%0d it=%0d",
						want.position, want.status, want.iterations_used,
						got.position, got.status, got.iterations_used);
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [0:0]  cfg_index;
	logic [15:0] cfg_data;
	logic        in_valid;
	logic        in_ready;
	in_t         in_data;
	logic        out_valid;
	logic        out_ready;
	out_t        out_data;

	lagrange_scoreboard sb;
	int send_idle, recv_idle, hold_cycles, quiet;

	inner_lagrange_point_newton_solver u_top (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check(out_data);
		if ((in_valid && in_ready) || (out_valid && out_ready) || !arst_n)
			quiet = 0;
		else
			quiet++;
		if (quiet >= STALL_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// receiver: random stalls, or a long hold when requested
	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				out_ready = 1'b0;
				hold_cycles--;
			end else
				out_ready = ($urandom_range(99) >= recv_idle);
		end
	end

	task automatic write_reg(logic [0:0] idx, logic [15:0] val);
		@(negedge clk);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_data  = val;
		@(negedge clk);
		cfg_we = 1'b0;
		if (idx == CFG_MAX_ITER)
			sb.iter_limit = val[9:0];
		else
			sb.tol_lsbs = val;
	endtask

	task automatic send_request(in_t d);
		while ($urandom_range(99) < send_idle) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_data  = d;
		in_valid = 1'b1;
		do @(posedge clk); while (!in_ready);
		sb.note(d);
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	task automatic drain();
		while (sb.solutions.size() != 0)
			@(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	function automatic in_t make_request(logic k, logic [31:0] q, logic [31:0] s);
		in_t d;
		d.kind        = k;
		d.mass_ratio  = q;
		d.spin_factor = s;
		return d;
	endfunction

	function automatic in_t random_request();
		int          r;
		logic [31:0] s;
		r = $urandom_range(99);
		if (r < 10)
			return make_request(1'($urandom_range(1)), 32'd0, $urandom);
		if (r < 25)
			return make_request(1'($urandom_range(1)), $urandom, $urandom);
		s = $urandom_range(32'h3000_0000);
		if ($urandom_range(1))
			s = -s;
		return make_request(1'($urandom_range(1)), $urandom_range(32'h20_0000, 32'h800), s);
	endfunction

	int     phase_iter[5] = '{1, 8, 4, 1023, 6};
	int     phase_tol[5]  = '{0, 1, 65535, 65535, 0};
	int     phase_cnt[5]  = '{150, 300, 200, 4, 230};
	in_t    dir[$];
	int     sent;

	initial begin
		sb          = new();
		clk         = 1'b0;
		arst_n      = 1'b0;
		cfg_we      = 1'b0;
		cfg_index   = CFG_MAX_ITER;
		cfg_data    = '0;
		in_valid    = 1'b0;
		in_data     = '0;
		send_idle   = 12;
		recv_idle   = 86;
		hold_cycles = 0;
		quiet       = 0;
		sent        = 0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		write_reg(CFG_MAX_ITER, 16'd24);
		dir = '{
			make_request(0, 32'd0, 32'd0),
			make_request(1, 32'd0, 32'hFFFF_FFFF),
			make_request(0, 32'd1, 32'd0),
			make_request(1, 32'd1, 32'd0),
			make_request(0, 32'hFFFF_FFFF, 32'd0),
			make_request(1, 32'hFFFF_FFFF, 32'h7FFF_FFFF),
			make_request(0, 32'h0001_0000, 32'd0),
			make_request(1, 32'h0001_0000, 32'd0),
			make_request(0, 32'h0001_0000, 32'h1000_0000),
			make_request(1, 32'h0001_0000, 32'h1000_0000),
			make_request(0, 32'h0000_8000, 32'h7FFF_FFFF),
			make_request(1, 32'h0000_8000, 32'h8000_0000),
			make_request(0, 32'h0002_0000, 32'h8000_0000),
			make_request(1, 32'h0002_0000, 32'hFFFF_FFFF),
			make_request(0, 32'h000A_0000, 32'd1),
			make_request(1, 32'h000A_0000, 32'hF000_0000),
			make_request(0, 32'h0000_1000, 32'h0800_0000),
			make_request(1, 32'h0000_1000, 32'hF800_0000),
			make_request(0, 32'h8000_0000, 32'h0000_0000),
			make_request(1, 32'h0064_0000, 32'h0400_0000)
		};
		foreach (dir[i]) begin
			// hold off the receiver while requests pile up
			if (i == 2)
				hold_cycles = 3000;
			send_request(dir[i]);
		end

		for (int p = 0; p < 5; p++) begin
			drain();
			write_reg(CFG_MAX_ITER, 16'(phase_iter[p]));
			write_reg(CFG_STEP_TOL, 16'(phase_tol[p]));
			for (int i = 0; i < phase_cnt[p]; i++) begin
				if (sent == 300) begin
					send_idle = 86;
					recv_idle = 12;
				end else if (sent == 600) begin
					send_idle = 0;
					recv_idle = 0;
				end
				send_request(p == 3 ? make_request(1'($urandom_range(1)),
					$urandom_range(32'h4_0000, 32'h4000), $urandom_range(32'h0400_0000))
					: random_request());
				sent++;
			end
		end

		drain();
		repeat (200) @(negedge clk);
		if (sb.mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
